FILE: hdl/hsvc_pkg.sv
package hsvc_pkg;

    localparam int IN_W  = 8;
    localparam int HUE_W = 16;
    localparam int SAT_W = 8;
    localparam int VAL_W = 8;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] value;
    } t_result;

endpackage

FILE: hdl/hsvc_sort.sv
module hsvc_sort #(
    parameter int CHAN_W = 8
) (
    input  logic [CHAN_W-1:0] i_red,
    input  logic [CHAN_W-1:0] i_grn,
    input  logic [CHAN_W-1:0] i_blu,
    output logic [CHAN_W-1:0] o_max,
    output logic [CHAN_W-1:0] o_min,
    output hsvc_pkg::t_sector o_sector
);
    import hsvc_pkg::*;

    logic w_red_max;
    logic w_grn_max;
    logic w_red_min;
    logic w_grn_min;

    assign w_red_max = (i_red >= i_grn) && (i_red >= i_blu);
    assign w_grn_max = (i_grn >= i_blu);
    assign w_red_min = (i_red <= i_grn) && (i_red <= i_blu);
    assign w_grn_min = (i_grn <= i_blu);

    always_comb begin
        if (w_red_max) begin
            o_max    = i_red;
            o_sector = SEC_RED;
        end else if (w_grn_max) begin
            o_max    = i_grn;
            o_sector = SEC_GREEN;
        end else begin
            o_max    = i_blu;
            o_sector = SEC_BLUE;
        end
        if (w_red_min) begin
            o_min = i_red;
        end else if (w_grn_min) begin
            o_min = i_grn;
        end else begin
            o_min = i_blu;
        end
    end

endmodule

FILE: hdl/hsvc_prep.sv
module hsvc_prep #(
    parameter int CHAN_W = 8
) (
    input  logic [CHAN_W-1:0]          i_red,
    input  logic [CHAN_W-1:0]          i_grn,
    input  logic [CHAN_W-1:0]          i_blu,
    input  logic [CHAN_W-1:0]          i_max,
    input  logic [CHAN_W-1:0]          i_min,
    input  hsvc_pkg::t_sector          i_sector,
    output logic [CHAN_W+2:0]          o_hue_rem,
    output logic [CHAN_W+2:0]          o_hue_den,
    output logic [CHAN_W-1:0]          o_sat_rem,
    output logic [CHAN_W-1:0]          o_sat_div,
    output logic [hsvc_pkg::SAT_W-1:0] o_sat_low,
    output logic [hsvc_pkg::VAL_W-1:0] o_value
);
    import hsvc_pkg::*;

    localparam int DW = CHAN_W + 3;
    localparam int NW = DW + 2;
    localparam int PW = CHAN_W + SAT_W;

    logic [CHAN_W-1:0]    w_delta;
    logic                 w_grey;
    logic signed [NW-1:0] w_d;
    logic signed [NW-1:0] w_r;
    logic signed [NW-1:0] w_g;
    logic signed [NW-1:0] w_b;
    logic signed [NW-1:0] w_num;
    logic signed [NW-1:0] w_wrap;
    logic [DW-1:0]        w_den;
    logic [PW-1:0]        w_sprod;

    assign w_delta = i_max - i_min;
    assign w_grey  = (w_delta == '0);

    assign w_d = $signed({{(NW-CHAN_W){1'b0}}, w_delta});
    assign w_r = $signed({{(NW-CHAN_W){1'b0}}, i_red});
    assign w_g = $signed({{(NW-CHAN_W){1'b0}}, i_grn});
    assign w_b = $signed({{(NW-CHAN_W){1'b0}}, i_blu});

    always_comb begin
        case (i_sector)
            SEC_RED:   w_num = w_g - w_b;
            SEC_GREEN: w_num = (w_d <<< 1) + w_b - w_r;
            SEC_BLUE:  w_num = (w_d <<< 2) + w_r - w_g;
            default:   w_num = '0;
        endcase
        if (w_num < 0) begin
            w_wrap = w_num + (w_d <<< 2) + (w_d <<< 1);
        end else begin
            w_wrap = w_num;
        end
    end

    assign w_den   = (DW'(w_delta) << 2) + (DW'(w_delta) << 1);
    assign w_sprod = {w_delta, {SAT_W{1'b0}}} - PW'(w_delta);

    assign o_hue_rem = w_grey ? '0 : w_wrap[DW-1:0];
    assign o_hue_den = w_grey ? DW'(1) : w_den;
    assign o_sat_rem = w_sprod[PW-1:SAT_W];
    assign o_sat_low = w_sprod[SAT_W-1:0];
    assign o_sat_div = w_grey ? CHAN_W'(1) : i_max;
    assign o_value   = VAL_W'(i_max);

endmodule

FILE: hdl/hsvc_div_step.sv
module hsvc_div_step #(
    parameter int REM_W = 11
) (
    input  logic [REM_W-1:0] i_rem,
    input  logic [REM_W-1:0] i_den,
    input  logic             i_bit,
    output logic [REM_W-1:0] o_rem,
    output logic             o_qbit
);
    logic [REM_W:0]   w_shift;
    logic [REM_W+1:0] w_diff;

    assign w_shift = {i_rem, i_bit};
    assign w_diff  = {1'b0, w_shift} - {2'b00, i_den};
    assign o_qbit  = ~w_diff[REM_W+1];
    assign o_rem   = o_qbit ? w_diff[REM_W-1:0] : w_shift[REM_W-1:0];

endmodule

FILE: hdl/rgb_to_hsv_converter.sv
// Converts one RGB pixel per clock into hue, saturation and value. Each channel keeps its
// low min(CHANNEL_BITS, 8) bits. Value is the largest channel, saturation is
// floor(delta*255/max), and hue is floor(65536*n/(6*delta)) with n = (2*sector*delta+diff)
// mod (6*delta), as a 16-bit fraction of a full turn; a grey pixel gives hue 0 and
// saturation 0. Throughput is one pixel per clock while o_stall is low. From request
// acceptance to o_valid a pixel passes the input register, which loads at acceptance,
// then max/min sort, difference prep, 16 restoring divider stages (one hue quotient bit
// each, the first 8 also producing saturation bits) and the output register. A skid
// register behind the output absorbs one result, so o_stall rises only when both are full.
module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [hsvc_pkg::IN_W-1:0]   i_red_in,
    input  logic [hsvc_pkg::IN_W-1:0]   i_green_in,
    input  logic [hsvc_pkg::IN_W-1:0]   i_blue_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hsvc_pkg::HUE_W-1:0]  o_hue_out,
    output logic [hsvc_pkg::SAT_W-1:0]  o_sat_out,
    output logic [hsvc_pkg::VAL_W-1:0]  o_value_out
);
    import hsvc_pkg::*;

    localparam int W    = (CHANNEL_BITS < IN_W) ? CHANNEL_BITS : IN_W;
    localparam int DW   = W + 3;
    localparam int NSTG = 3 + HUE_W;

    typedef struct packed {
        logic [W-1:0] red;
        logic [W-1:0] grn;
        logic [W-1:0] blu;
    } t_rgb;

    typedef struct packed {
        t_rgb         rgb;
        logic [W-1:0] mx;
        logic [W-1:0] mn;
        t_sector      sector;
    } t_srt;

    typedef struct packed {
        logic [DW-1:0]    hrem;
        logic [DW-1:0]    hden;
        logic [HUE_W-1:0] hq;
        logic [W-1:0]     srem;
        logic [W-1:0]     sdiv;
        logic [SAT_W-1:0] slow;
        logic [SAT_W-1:0] sq;
        logic [VAL_W-1:0] value;
    } t_div;

    logic [NSTG-1:0] r_vld;
    t_rgb            r_rgb;
    t_rgb            n_rgb;
    t_srt            r_srt;
    t_srt            n_srt;
    t_div            r_div [0:HUE_W];
    t_div            n_div0;
    t_div            n_div [1:HUE_W];
    logic            r_out_vld;
    logic            r_skid_vld;
    t_result         r_out;
    t_result         r_skid;

    logic            w_adv;
    logic            w_out_free;
    t_result         w_last;
    logic [DW-1:0]   w_hrem [1:HUE_W];
    logic            w_hbit [1:HUE_W];
    logic [W-1:0]    w_srem [1:SAT_W];
    logic            w_sbit [1:SAT_W];

    assign w_adv      = ~r_skid_vld;
    assign w_out_free = ~r_out_vld | ~i_stall;
    assign o_stall    = r_skid_vld;

    assign n_rgb.red = i_red_in[W-1:0];
    assign n_rgb.grn = i_green_in[W-1:0];
    assign n_rgb.blu = i_blue_in[W-1:0];

    assign n_srt.rgb = r_rgb;

    hsvc_sort #(.CHAN_W(W)) u_sort (
        .i_red    (r_rgb.red),
        .i_grn    (r_rgb.grn),
        .i_blu    (r_rgb.blu),
        .o_max    (n_srt.mx),
        .o_min    (n_srt.mn),
        .o_sector (n_srt.sector)
    );

    hsvc_prep #(.CHAN_W(W)) u_prep (
        .i_red     (r_srt.rgb.red),
        .i_grn     (r_srt.rgb.grn),
        .i_blu     (r_srt.rgb.blu),
        .i_max     (r_srt.mx),
        .i_min     (r_srt.mn),
        .i_sector  (r_srt.sector),
        .o_hue_rem (n_div0.hrem),
        .o_hue_den (n_div0.hden),
        .o_sat_rem (n_div0.srem),
        .o_sat_div (n_div0.sdiv),
        .o_sat_low (n_div0.slow),
        .o_value   (n_div0.value)
    );

    assign n_div0.hq = '0;
    assign n_div0.sq = '0;

    for (genvar j = 1; j <= HUE_W; j++) begin : g_hue
        hsvc_div_step #(.REM_W(DW)) u_hue_step (
            .i_rem  (r_div[j-1].hrem),
            .i_den  (r_div[j-1].hden),
            .i_bit  (1'b0),
            .o_rem  (w_hrem[j]),
            .o_qbit (w_hbit[j])
        );
    end

    for (genvar j = 1; j <= SAT_W; j++) begin : g_sat
        hsvc_div_step #(.REM_W(W)) u_sat_step (
            .i_rem  (r_div[j-1].srem),
            .i_den  (r_div[j-1].sdiv),
            .i_bit  (r_div[j-1].slow[SAT_W-1]),
            .o_rem  (w_srem[j]),
            .o_qbit (w_sbit[j])
        );
    end

    always_comb begin
        for (int j = 1; j <= HUE_W; j++) begin
            n_div[j]      = r_div[j-1];
            n_div[j].hrem = w_hrem[j];
            n_div[j].hq   = {r_div[j-1].hq[HUE_W-2:0], w_hbit[j]};
        end
        for (int j = 1; j <= SAT_W; j++) begin
            n_div[j].srem = w_srem[j];
            n_div[j].slow = {r_div[j-1].slow[SAT_W-2:0], 1'b0};
            n_div[j].sq   = {r_div[j-1].sq[SAT_W-2:0], w_sbit[j]};
        end
    end

    assign w_last.hue   = r_div[HUE_W].hq;
    assign w_last.sat   = r_div[HUE_W].sq;
    assign w_last.value = r_div[HUE_W].value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[NSTG-2:0], i_valid};
            end
            if (r_skid_vld) begin
                if (w_out_free) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end
            end else if (r_vld[NSTG-1]) begin
                if (w_out_free) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (w_out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rgb    <= n_rgb;
            r_srt    <= n_srt;
            r_div[0] <= n_div0;
            for (int j = 1; j <= HUE_W; j++) begin
                r_div[j] <= n_div[j];
            end
        end
        if (r_skid_vld) begin
            if (w_out_free) begin
                r_out <= r_skid;
            end
        end else if (w_out_free) begin
            r_out <= w_last;
        end else begin
            r_skid <= w_last;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_hue_out   = r_out.hue;
    assign o_sat_out   = r_out.sat;
    assign o_value_out = r_out.value;

endmodule

FILE: verif/rgb_to_hsv_converter_test.sv
module rgb_to_hsv_converter_test;

    import hsvc_pkg::*;

    localparam int STUCK_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 550;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [IN_W-1:0]  i_red_in = '0;
    logic [IN_W-1:0]  i_green_in = '0;
    logic [IN_W-1:0]  i_blue_in = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [HUE_W-1:0] o_hue_out;
    logic [SAT_W-1:0] o_sat_out;
    logic [VAL_W-1:0] o_value_out;

    t_result pending_hsv[$];
    int      mismatches = 0;
    int      stuck_cycles = 0;
    bit      calm = 1'b0;

    rgb_to_hsv_converter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hue_out   (o_hue_out),
        .o_sat_out   (o_sat_out),
        .o_value_out (o_value_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result predict_hsv(input logic [IN_W-1:0] r, g, b);
        int      red, grn, blu, top, bottom, delta, num;
        t_sector sector;
        t_result res;
        red = int'(r);
        grn = int'(g);
        blu = int'(b);
        top = red;
        bottom = red;
        if (grn > top) top = grn;
        if (blu > top) top = blu;
        if (grn < bottom) bottom = grn;
        if (blu < bottom) bottom = blu;
        delta = top - bottom;
        res.value = VAL_W'(top);
        res.hue = '0;
        res.sat = '0;
        if (delta != 0) begin
            if (red == top) sector = SEC_RED;
            else if (grn == top) sector = SEC_GREEN;
            else sector = SEC_BLUE;
            case (sector)
                SEC_RED:   num = grn - blu;
                SEC_GREEN: num = 2 * delta + blu - red;
                default:   num = 4 * delta + red - grn;
            endcase
            if (num < 0) num += 6 * delta;
            res.sat = SAT_W'((delta * 255) / top);
            res.hue = HUE_W'((num * 65536) / (6 * delta));
        end
        return res;
    endfunction

    task automatic send_pixel(input logic [IN_W-1:0] r, g, b);
        while (!calm && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_hsv.push_back(predict_hsv(r, g, b));
    endtask

    task automatic test_extremes();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd170, 8'd85, 8'd0);
    endtask

    task automatic test_ties_and_wrap();
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd200, 8'd200, 8'd200);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd100, 8'd20, 8'd99);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd1);
        send_pixel(8'd90, 8'd200, 8'd240);
    endtask

    task automatic test_random_pixels();
        logic [IN_W-1:0] r, g, b, base;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 250 && n < 350);
            r = IN_W'($urandom);
            g = IN_W'($urandom);
            b = IN_W'($urandom);
            base = IN_W'($urandom_range(0, 253));
            case ($urandom_range(9))
                6: begin
                    g = r;
                    b = r;
                end
                7: begin
                    case ($urandom_range(2))
                        0: g = r;
                        1: b = g;
                        default: b = r;
                    endcase
                end
                8: begin
                    r = base + IN_W'($urandom_range(2));
                    g = base + IN_W'($urandom_range(2));
                    b = base + IN_W'($urandom_range(2));
                end
                9: begin
                    r = $urandom_range(1) ? 8'd255 : 8'd0;
                    g = $urandom_range(1) ? 8'd255 : 8'd0;
                    b = $urandom_range(1) ? 8'd255 : 8'd0;
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 14);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_hsv.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hue %h sat %h value %h",
                         $time, o_hue_out, o_sat_out, o_value_out);
                mismatches++;
            end else begin
                want = pending_hsv.pop_front();
                if (o_hue_out !== want.hue) begin
                    $display("%0t: hue expected %h actual %h", $time, want.hue, o_hue_out);
                    mismatches++;
                end
                if (o_sat_out !== want.sat) begin
                    $display("%0t: sat expected %h actual %h", $time, want.sat, o_sat_out);
                    mismatches++;
                end
                if (o_value_out !== want.value) begin
                    $display("%0t: value expected %h actual %h", $time, want.value,
                             o_value_out);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) stuck_cycles = 0;
            else stuck_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_ties_and_wrap();
        test_random_pixels();
        i_valid <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_hsv.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
